### src/rspc_pkg.sv
package rspc_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int GAIN_W     = 16;
    localparam int PERIOD_W   = 16;
    localparam int MODE_W     = 3;
    localparam int DRIVE_W    = 8;
    localparam int DRIVE_MAX  = 100;
    localparam int FRAC_BITS  = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = (ANGLE_BITS > GAIN_W) ? ANGLE_BITS : GAIN_W;

    localparam logic [MODE_W-1:0] MODE_DOWN   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STAND  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_DOWN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_UP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LOOKUP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_PUSH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_PERIOD  = 3'd6;

    localparam logic [GAIN_W-1:0]   KP_RESET     = GAIN_W'(256);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);

    typedef logic signed [ANGLE_BITS-1:0] t_angle;

endpackage

### src/ramped_setpoint_p_controller.sv
// Ramped-setpoint proportional controller. One request is one control tick
// (mode and measured angle) and yields one result (drive and new setpoint).
// A request is taken every clock cycle while o_in_stall is low; the first stage
// updates the setpoint and tick counter and forms the error, the second multiplies
// by the gain, truncates toward zero and clamps to +/-100 into the output register.
// The user must write registers through the config port only while no request is
// in flight; the block itself does not enforce this.
module ramped_setpoint_p_controller
    import rspc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,

    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [MODE_W-1:0]      i_tail_mode,
    input  logic signed [ANGLE_BITS-1:0] i_measured_angle,

    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [DRIVE_W-1:0]    o_motor_drive,
    output logic signed [ANGLE_BITS-1:0] o_setpoint_now
);

    localparam int ERR_W  = ANGLE_BITS + 1;
    localparam int PROD_W = ERR_W + GAIN_W + 1;
    localparam logic signed [PROD_W-1:0] LIM_HI = PROD_W'(DRIVE_MAX);
    localparam logic signed [PROD_W-1:0] LIM_LO = -PROD_W'(DRIVE_MAX);

    t_angle                r_ang_down, r_ang_up, r_ang_lookup, r_ang_stand, r_ang_push;
    logic [GAIN_W-1:0]     r_kp;
    logic [PERIOD_W-1:0]   r_period;

    t_angle                r_sp, n_sp;
    logic [PERIOD_W-1:0]   r_tick, n_tick;

    logic                  r_s1_valid;
    logic signed [ERR_W-1:0] r_s1_err;
    t_angle                r_s1_sp;

    logic                  r_out_valid;
    logic signed [DRIVE_W-1:0] r_out_drive;
    t_angle                r_out_sp;

    logic                  out_ready, s1_adv, in_acc;
    t_angle                target, base;
    logic [PERIOD_W-1:0]   tick_inc;
    logic                  step;
    logic signed [ERR_W-1:0] n_err;
    logic signed [PROD_W-1:0] prod, quo, clamped;

    // handshake
    assign out_ready   = !r_out_valid || !i_out_stall;
    assign s1_adv      = r_s1_valid && out_ready;
    assign o_in_stall  = r_s1_valid && !out_ready;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_motor_drive  = r_out_drive;
    assign o_setpoint_now = r_out_sp;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_down   <= '0;
            r_ang_up     <= '0;
            r_ang_lookup <= '0;
            r_ang_stand  <= '0;
            r_ang_push   <= '0;
            r_kp         <= KP_RESET;
            r_period     <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ANGLE_DOWN:   r_ang_down   <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_ANGLE_UP:     r_ang_up     <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_ANGLE_LOOKUP: r_ang_lookup <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_ANGLE_STAND:  r_ang_stand  <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_ANGLE_PUSH:   r_ang_push   <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_KP_GAIN:      r_kp         <= i_cfg_data[GAIN_W-1:0];
                CFG_RAMP_PERIOD:  r_period     <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: target select, ramp update, error
    always_comb begin
        unique case (i_tail_mode)
            MODE_DOWN:   target = r_ang_down;
            MODE_UP:     target = r_ang_up;
            MODE_LOOKUP: target = r_ang_lookup;
            MODE_STAND:  target = r_ang_stand;
            MODE_PUSH:   target = r_ang_push;
            default:     target = r_sp;
        endcase
        base     = (i_tail_mode == MODE_UP) ? target : r_sp;
        tick_inc = r_tick + PERIOD_W'(1);
        step     = (tick_inc >= r_period);
        n_sp     = base;
        n_tick   = tick_inc;
        if (step) begin
            n_tick = '0;
            if (target > base) begin
                n_sp = base + t_angle'(1);
            end else if (target < base) begin
                n_sp = base - t_angle'(1);
            end
        end
        n_err = ERR_W'(n_sp) - ERR_W'(i_measured_angle);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp       <= '0;
            r_tick     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_sp   <= n_sp;
                r_tick <= n_tick;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_err <= n_err;
            r_s1_sp  <= n_sp;
        end
    end

    // stage 2: gain, truncate toward zero, clamp
    always_comb begin
        prod = PROD_W'(r_s1_err) * $signed({1'b0, r_kp});
        quo  = (prod >>> FRAC_BITS)
             + $signed(PROD_W'(prod[PROD_W-1] && (|prod[FRAC_BITS-1:0])));
        if (quo > LIM_HI) begin
            clamped = LIM_HI;
        end else if (quo < LIM_LO) begin
            clamped = LIM_LO;
        end else begin
            clamped = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_drive <= clamped[DRIVE_W-1:0];
            r_out_sp    <= r_s1_sp;
        end
    end

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_motor_drive <= DRIVE_W'(DRIVE_MAX)
                         && o_motor_drive >= -DRIVE_W'(DRIVE_MAX)))
        else $error("drive out of range");

    a_ramp_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_tail_mode != MODE_UP) |=>
            (r_sp == $past(r_sp) || r_sp == $past(r_sp) + t_angle'(1)
             || r_sp == $past(r_sp) - t_angle'(1)))
        else $error("setpoint moved more than one unit");

    a_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && step) |=> (r_tick == '0))
        else $error("tick count not cleared on step");

    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("stage 1 request lost");

endmodule

### verif/ramped_setpoint_p_controller_checker.sv
module ramped_setpoint_p_controller_checker
    import rspc_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [MODE_W-1:0]            i_tail_mode,
    input  logic signed [ANGLE_BITS-1:0] i_measured_angle,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic signed [DRIVE_W-1:0]    i_motor_drive,
    input  logic signed [ANGLE_BITS-1:0] i_setpoint_now,
    output int                           o_fail_count,
    output int                           o_outstanding,
    output int                           o_ticks_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_TARGETS  = int'(CFG_ANGLE_PUSH) + 1;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        t_angle                    setpoint;
    } t_tick_result;

    t_angle              mode_target [N_TARGETS];
    logic [GAIN_W-1:0]   kp;
    logic [PERIOD_W-1:0] period;
    t_angle              setpoint;
    logic [PERIOD_W-1:0] ticks;
    t_tick_result        drive_q [$];

    task automatic flag(input string what, input longint want, input longint got);
        o_fail_count++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endtask

    // advances the setpoint/tick state by one control tick and returns the expected drive and setpoint
    function automatic t_tick_result control_tick(input logic [MODE_W-1:0] mode,
                                                  input t_angle measured);
        t_angle       goal;
        longint       err;
        longint       drive;
        t_tick_result r;
        goal = (mode <= MODE_PUSH) ? mode_target[mode] : setpoint;
        if (mode == MODE_UP)
            setpoint = goal;
        ticks = ticks + 1'b1;
        if (ticks >= period) begin
            if (setpoint < goal)
                setpoint = setpoint + t_angle'(1);
            else if (setpoint > goal)
                setpoint = setpoint - t_angle'(1);
            ticks = '0;
        end
        err   = longint'(setpoint) - longint'(measured);
        drive = (longint'(kp) * err) / (longint'(1) << FRAC_BITS);   // truncates toward zero
        if (drive > DRIVE_MAX)
            drive = DRIVE_MAX;
        else if (drive < -DRIVE_MAX)
            drive = -DRIVE_MAX;
        r.drive    = DRIVE_W'(drive);
        r.setpoint = setpoint;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_tick_result want;
        if (!i_rst_n) begin
            foreach (mode_target[k])
                mode_target[k] = '0;
            kp       = KP_RESET;
            period   = PERIOD_RESET;
            setpoint = '0;
            ticks    = '0;
            drive_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (drive_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result with no request pending: drive %0d setpoint %0d",
                             $time, i_motor_drive, i_setpoint_now);
                end else begin
                    want = drive_q.pop_front();
                    if (i_motor_drive !== want.drive)
                        flag("motor_drive", want.drive, i_motor_drive);
                    if (i_setpoint_now !== want.setpoint)
                        flag("setpoint_now", want.setpoint, i_setpoint_now);
                    o_ticks_checked++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ANGLE_DOWN, CFG_ANGLE_UP, CFG_ANGLE_LOOKUP,
                    CFG_ANGLE_STAND, CFG_ANGLE_PUSH: begin
                        mode_target[i_cfg_index] = i_cfg_data[ANGLE_BITS-1:0];
                    end
                    CFG_KP_GAIN: begin
                        kp = i_cfg_data[GAIN_W-1:0];
                    end
                    CFG_RAMP_PERIOD: begin
                        period = i_cfg_data[PERIOD_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall)
                drive_q.push_back(control_tick(i_tail_mode, i_measured_angle));
        end
        o_outstanding = drive_q.size();
    end

endmodule

### verif/tb_ramped_setpoint_p_controller.sv
module tb_ramped_setpoint_p_controller
    import rspc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     N_TARGETS   = int'(CFG_ANGLE_PUSH) + 1;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     HOLD_CYCLES = 150;
    localparam int     BATCH       = 54;
    localparam t_angle ANGLE_MIN   = {1'b1, {(ANGLE_BITS-1){1'b0}}};
    localparam t_angle ANGLE_MAX   = ~ANGLE_MIN;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_W-1:0]      cfg_data     = '0;
    logic                  req_valid    = 1'b0;
    logic                  req_stall;
    logic [MODE_W-1:0]     req_mode     = MODE_DOWN;
    t_angle                req_angle    = '0;
    logic                  rsp_valid;
    logic                  rsp_stall    = 1'b0;
    logic signed [DRIVE_W-1:0] rsp_drive;
    t_angle                rsp_setpoint;

    int     fail_count;
    int     outstanding;
    int     ticks_checked;
    int     cycles         = 0;
    int     send_idle      = 0;
    int     recv_idle      = 0;
    int     hold_requests  = 0;
    int     holds_done     = 0;
    int     settings_count = 0;
    t_angle aim [N_TARGETS];

    ramped_setpoint_p_controller dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (req_valid),
        .o_in_stall       (req_stall),
        .i_tail_mode      (req_mode),
        .i_measured_angle (req_angle),
        .o_out_valid      (rsp_valid),
        .i_out_stall      (rsp_stall),
        .o_motor_drive    (rsp_drive),
        .o_setpoint_now   (rsp_setpoint)
    );

    ramped_setpoint_p_controller_checker checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (req_valid),
        .i_in_stall       (req_stall),
        .i_tail_mode      (req_mode),
        .i_measured_angle (req_angle),
        .i_out_valid      (rsp_valid),
        .i_out_stall      (rsp_stall),
        .i_motor_drive    (rsp_drive),
        .i_setpoint_now   (rsp_setpoint),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding),
        .o_ticks_checked  (ticks_checked)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ramped_setpoint_p_controller regression: fail");
            $finish;
        end
    end

    // output side: random stalls, plus a long hold-off when asked
    initial begin
        forever begin
            @(negedge clk);
            if (hold_requests != holds_done) begin
                holds_done++;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                rsp_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx <= CFG_ANGLE_PUSH)
            aim[idx] = val[ANGLE_BITS-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_setting(input t_angle dn, input t_angle up, input t_angle look,
                                input t_angle stand, input t_angle push,
                                input logic [GAIN_W-1:0] gain,
                                input logic [PERIOD_W-1:0] per);
        write_reg(CFG_ANGLE_DOWN, dn);
        write_reg(CFG_ANGLE_UP, up);
        write_reg(CFG_ANGLE_LOOKUP, look);
        write_reg(CFG_ANGLE_STAND, stand);
        write_reg(CFG_ANGLE_PUSH, push);
        write_reg(CFG_KP_GAIN, gain);
        write_reg(CFG_RAMP_PERIOD, per);
        settings_count++;
    endtask

    task automatic send_tick(input logic [MODE_W-1:0] mode, input t_angle angle);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_mode  <= mode;
        req_angle <= angle;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic settle;
        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    function automatic t_angle pick_angle(input t_angle near);
        case ($urandom_range(3))
            0:       return t_angle'($urandom);
            3:       return $urandom_range(1) ? ANGLE_MAX : ANGLE_MIN;
            default: return near + t_angle'($urandom_range(600)) - t_angle'(300);
        endcase
    endfunction

    function automatic t_angle pick_target(input bit wide);
        if (wide)
            return $urandom_range(1) ? ANGLE_MAX : ANGLE_MIN;
        return t_angle'($urandom_range(800)) - t_angle'(400);
    endfunction

    task automatic random_setting(input int style);
        logic [GAIN_W-1:0]   gain;
        logic [PERIOD_W-1:0] per;
        case (style)
            0: begin
                gain = '1;
                per  = PERIOD_W'(1);
            end
            1: begin
                gain = '0;
                per  = '1;
            end
            default: begin
                case ($urandom_range(2))
                    0:       gain = KP_RESET;
                    1:       gain = GAIN_W'($urandom);
                    default: gain = GAIN_W'($urandom_range(1024, 1));
                endcase
                per = PERIOD_W'($urandom_range(6, 1));
            end
        endcase
        load_setting(pick_target(style == 0), pick_target(style == 0),
                     pick_target(style == 0), pick_target(style == 0),
                     pick_target(style == 0), gain, per);
    endtask

    task automatic random_batch;
        logic [MODE_W-1:0] mode;
        repeat (BATCH) begin
            if ($urandom_range(19) == 0)
                mode = MODE_W'($urandom_range((1 << MODE_W) - 1, int'(MODE_PUSH) + 1));
            else
                mode = MODE_W'($urandom_range(int'(MODE_PUSH)));
            send_tick(mode, pick_angle(mode <= MODE_PUSH ? aim[mode] : t_angle'(0)));
        end
    endtask

    initial begin
        int idle_mix [3][2];
        int step;
        idle_mix = '{'{8, 86}, '{86, 8}, '{0, 0}};
        foreach (aim[k])
            aim[k] = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reset values of the registers
        send_tick(MODE_DOWN, '0);
        send_tick(MODE_PUSH, 16'sd5);
        settle();

        load_setting(ANGLE_MIN, ANGLE_MAX, 16'sd123, -16'sd7, '0, '1, PERIOD_W'(1));
        send_tick(MODE_UP, ANGLE_MIN);
        send_tick(MODE_UP, ANGLE_MAX);
        send_tick(MODE_UP, '0);
        send_tick(MODE_DOWN, ANGLE_MAX);
        send_tick(MODE_DOWN, ANGLE_MIN);
        send_tick(MODE_LOOKUP, '0);
        send_tick(MODE_STAND, -16'sd1);
        send_tick(MODE_PUSH, 16'sd1);
        for (int m = int'(MODE_PUSH) + 1; m < (1 << MODE_W); m++)
            send_tick(MODE_W'(m), t_angle'($urandom));
        settle();

        // small gain, negative error: truncation toward zero
        load_setting('0, -16'sd300, '0, -16'sd200, '0, GAIN_W'(3), PERIOD_W'(5));
        send_tick(MODE_UP, '0);
        send_tick(MODE_STAND, -16'sd200);
        send_tick(MODE_STAND, -16'sd200);
        send_tick(MODE_STAND, 16'sd100);
        settle();

        // period dropped below the running count
        write_reg(CFG_RAMP_PERIOD, PERIOD_W'(2));
        send_tick(MODE_STAND, '0);
        send_tick(MODE_STAND, '0);
        settle();

        write_reg(CFG_KP_GAIN, '0);
        send_tick(MODE_PUSH, ANGLE_MAX);
        settle();

        for (int p = 0; p < 3; p++) begin
            send_idle = idle_mix[p][0];
            recv_idle = idle_mix[p][1];
            for (int k = 0; k < 4; k++) begin
                step = p * 4 + k;
                random_setting((step == 0 || step == 11) ? 0 : (step == 5) ? 1 : 2);
                if (p == 2 && k == 2)
                    hold_requests++;
                random_batch();
                settle();
            end
        end

        repeat (10) @(negedge clk);
        $display("%0d control ticks checked over %0d register settings, three idle mixes",
                 ticks_checked, settings_count);
        $display("and one long output hold-off with the request side kept busy");
        if (fail_count == 0)
            $display("ramped_setpoint_p_controller regression: pass");
        else
            $display("ramped_setpoint_p_controller regression: fail");
        $finish;
    end

endmodule
